[sv/dcpp_pkg.sv]
// Package for the drift circle pair point block: pipeline word, stage counts,
// saturation limits, register and status constants; used by every module.
package dcpp_pkg;

  localparam int unsigned RootSteps = 17;   // one result bit of the root per stage
  localparam int unsigned DivSteps  = 25;   // overflow bit plus 24 quotient bits
  localparam int unsigned TopBit    = 24;   // step that only detects overflow

  localparam logic [23:0] PtMax  = 24'h7FFFFF;
  localparam logic [23:0] PtMin  = 24'h800000;
  localparam logic [23:0] ErrMax = 24'hFFFFFF;

  localparam logic [15:0] UncertReset = 16'd64;

  // Byte address of the radius uncertainty register
  localparam logic [1:0] AddrUncert = 2'd0;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  // Word that travels down the pipeline; each stage works on its own part.
  typedef struct packed {
    logic        zero_d;   // combination denominator is zero
    logic        pt_zero;  // denominator of the point in use is zero
    logic        neg_x;
    logic        neg_y;
    logic [37:0] nx;       // point dividend / remainder
    logic [37:0] ny;
    logic [16:0] pd;       // point divisor magnitude
    logic [34:0] sq;       // radicand / root remainder
    logic [34:0] root;
    logic [36:0] ux;       // u * |dx|
    logic [36:0] uy;
    logic [54:0] ex;       // error dividend / remainder
    logic [54:0] ey;
    logic [33:0] d2;       // error divisor
    logic [23:0] qx;
    logic [23:0] qy;
    logic [23:0] qex;
    logic [23:0] qey;
    logic        ovx;
    logic        ovy;
    logic        ovex;
    logic        ovey;
  } item_t;

endpackage

[sv/dcpp_prep.sv]
// First stage: products, denominators and magnitudes of one input beat.
// Depends on dcpp_pkg.
module dcpp_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [1:0]      func_i,
  input  logic [19:0]     x_first_i,
  input  logic [19:0]     y_first_i,
  input  logic [15:0]     t_first_i,
  input  logic [19:0]     x_second_i,
  input  logic [19:0]     y_second_i,
  input  logic [15:0]     t_second_i,
  input  logic [15:0]     uncert_i,
  output logic            valid_o,
  output dcpp_pkg::item_t item_o
);

  logic                valid_q;
  dcpp_pkg::item_t     item_d, item_q;
  logic                minus, use_plus;
  logic signed [37:0]  t1e, t2e, x1e, y1e, x2e, y2e;
  logic signed [37:0]  px1, py1, px2, py2, nxs, nys;
  logic signed [17:0]  d, pdn;
  logic signed [20:0]  dx, dy;
  logic [20:0]         adx, ady;
  logic [36:0]         anx, any;
  logic [16:0]         ad, ad_c;

  always_comb begin
    minus    = (func_i == 2'd1) || (func_i == 2'd2);
    t1e      = $signed({22'd0, t_first_i});
    t2e      = $signed({22'd0, t_second_i});
    x1e      = 38'(signed'(x_first_i));
    y1e      = 38'(signed'(y_first_i));
    x2e      = 38'(signed'(x_second_i));
    y2e      = 38'(signed'(y_second_i));
    // combination denominator, and the plus fall-back for a zero minus
    d        = minus ? 18'(t1e - t2e) : 18'(t1e + t2e);
    use_plus = !minus || (d == 18'sd0);
    pdn      = use_plus ? 18'(t1e + t2e) : 18'(t1e - t2e);
    px1      = x1e * t2e;
    py1      = y1e * t2e;
    px2      = x2e * t1e;
    py2      = y2e * t1e;
    nxs      = use_plus ? px2 + px1 : px2 - px1;
    nys      = use_plus ? py2 + py1 : py2 - py1;
    anx      = nxs[37] ? 37'(-nxs) : 37'(nxs);
    any      = nys[37] ? 37'(-nys) : 37'(nys);
    ad       = pdn[17] ? 17'(-pdn) : 17'(pdn);
    ad_c     = minus ? (d[17] ? 17'(-d) : 17'(d)) : 17'(d);
    dx       = 21'(x2e - x1e);
    dy       = 21'(y2e - y1e);
    adx      = dx[20] ? 21'(-dx) : 21'(dx);
    ady      = dy[20] ? 21'(-dy) : 21'(dy);

    item_d         = '0;
    item_d.zero_d  = (d == 18'sd0);
    item_d.pt_zero = (pdn == 18'sd0);
    item_d.neg_x   = nxs[37] != pdn[17];
    item_d.neg_y   = nys[37] != pdn[17];
    item_d.nx      = 38'(anx) + 38'(ad >> 1);
    item_d.ny      = 38'(any) + 38'(ad >> 1);
    item_d.pd      = ad;
    item_d.sq      = 35'(34'(t_first_i) * 34'(t_first_i)) +
                     35'(34'(t_second_i) * 34'(t_second_i));
    item_d.ux      = 37'(uncert_i) * 37'(adx);
    item_d.uy      = 37'(uncert_i) * 37'(ady);
    item_d.d2      = 34'(ad_c) * 34'(ad_c);
  end

  // Advance the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/dcpp_root_step.sv]
// One digit step of the integer square root of t1^2 + t2^2, registered.
// Depends on dcpp_pkg.
module dcpp_root_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [4:0]      step_i,
  input  logic            valid_i,
  input  dcpp_pkg::item_t item_i,
  output logic            valid_o,
  output dcpp_pkg::item_t item_o
);

  logic            valid_q;
  dcpp_pkg::item_t item_d, item_q;
  logic [34:0]     bit_w, trial;

  // Try the next root bit and keep it where the remainder allows
  always_comb begin
    item_d = item_i;
    bit_w  = 35'd1 << {step_i, 1'b0};
    trial  = item_i.root + bit_w;
    if (item_i.sq >= trial) begin
      item_d.sq   = item_i.sq - trial;
      item_d.root = (item_i.root >> 1) + bit_w;
    end else begin
      item_d.root = item_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/dcpp_scale.sv]
// Scale stage: error dividend u*|d|*S plus half the divisor, registered.
// Depends on dcpp_pkg.
module dcpp_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  dcpp_pkg::item_t item_i,
  output logic            valid_o,
  output dcpp_pkg::item_t item_o
);

  logic            valid_q;
  dcpp_pkg::item_t item_d, item_q;

  // Multiply by the root and add half of D^2 for round-to-nearest
  always_comb begin
    item_d    = item_i;
    item_d.ex = 55'(item_i.ux) * 55'(item_i.root[16:0]) + 55'(item_i.d2 >> 1);
    item_d.ey = 55'(item_i.uy) * 55'(item_i.root[16:0]) + 55'(item_i.d2 >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/dcpp_div_step.sv]
// One restoring-division step for the two points and the two errors.
// The top step only flags overflow. Depends on dcpp_pkg.
module dcpp_div_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [4:0]      step_i,
  input  logic            valid_i,
  input  dcpp_pkg::item_t item_i,
  output logic            valid_o,
  output dcpp_pkg::item_t item_o
);

  logic            valid_q;
  dcpp_pkg::item_t item_d, item_q;
  logic [40:0]     pdiv;
  logic [57:0]     ediv;
  logic            gx, gy, gex, gey, top;

  always_comb begin
    item_d = item_i;
    pdiv   = 41'(item_i.pd) << step_i;
    ediv   = 58'(item_i.d2) << step_i;
    top    = (step_i == 5'(dcpp_pkg::TopBit));
    gx     = 41'(item_i.nx) >= pdiv;
    gy     = 41'(item_i.ny) >= pdiv;
    gex    = 58'(item_i.ex) >= ediv;
    gey    = 58'(item_i.ey) >= ediv;
    // subtract where the shifted divisor fits
    if (gx)  item_d.nx = 38'(41'(item_i.nx) - pdiv);
    if (gy)  item_d.ny = 38'(41'(item_i.ny) - pdiv);
    if (gex) item_d.ex = 55'(58'(item_i.ex) - ediv);
    if (gey) item_d.ey = 55'(58'(item_i.ey) - ediv);
    if (top) begin
      item_d.ovx  = gx;
      item_d.ovy  = gy;
      item_d.ovex = gex;
      item_d.ovey = gey;
    end else begin
      item_d.qx[step_i]  = gx;
      item_d.qy[step_i]  = gy;
      item_d.qex[step_i] = gex;
      item_d.qey[step_i] = gey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/drift_circle_pair_point.sv]
// Drift circle pair point: one track point and its error per wire pair.
// Depends on dcpp_pkg, dcpp_prep, dcpp_root_step, dcpp_scale, dcpp_div_step.
//
// A beat is taken on every cycle in which the output register is free or
// being emptied, so the block sustains one item per clock. Each item passes
// through one preparation stage, 17 square-root digit stages, one scaling
// multiply, 25 restoring-division stages shared by the two coordinates and
// the two errors, and the output register. A stall on the output freezes the
// whole pipeline; nothing is dropped or repeated.
// The radius uncertainty register sits at byte address 0 and should be
// written only while no item is in flight.
module drift_circle_pair_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  func_i,
  input  logic [19:0] x_first_i,
  input  logic [19:0] y_first_i,
  input  logic [15:0] t_first_i,
  input  logic [19:0] x_second_i,
  input  logic [19:0] y_second_i,
  input  logic [15:0] t_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] x_point_o,
  output logic [23:0] y_point_o,
  output logic [23:0] x_err_o,
  output logic [23:0] y_err_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NR = dcpp_pkg::RootSteps;
  localparam int unsigned ND = dcpp_pkg::DivSteps;

  logic [15:0]     uncert_q;
  logic            adv;
  logic            rv   [0:NR];
  dcpp_pkg::item_t ri   [0:NR];
  logic            dv   [0:ND];
  dcpp_pkg::item_t di   [0:ND];
  logic            out_valid_q;
  logic [23:0]     xp_d, yp_d, xe_d, ye_d, xp_q, yp_q, xe_q, ye_q;
  logic [1:0]      st_d, st_q;
  logic            sat_xp, sat_yp, sat_xe, sat_ye;
  dcpp_pkg::item_t fin;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uncert_q <= dcpp_pkg::UncertReset;
    end else if (psel && penable && pwrite && (paddr == dcpp_pkg::AddrUncert)) begin
      uncert_q <= pwdata[15:0];
    end
  end

  assign prdata = {16'd0, uncert_q};
  assign pready = 1'b1;

  // Whole pipeline moves unless a finished beat is held at the output
  assign adv     = !(out_valid_q && out_stall_i);
  assign stall_o = !adv;

  dcpp_prep u_prep (
    .clk_i, .rst_ni, .en_i(adv), .valid_i,
    .func_i, .x_first_i, .y_first_i, .t_first_i,
    .x_second_i, .y_second_i, .t_second_i,
    .uncert_i(uncert_q), .valid_o(rv[0]), .item_o(ri[0])
  );

  for (genvar r = 0; r < NR; r++) begin : g_root
    dcpp_root_step u_step (
      .clk_i, .rst_ni, .en_i(adv), .step_i(5'(NR - 1 - r)),
      .valid_i(rv[r]), .item_i(ri[r]), .valid_o(rv[r+1]), .item_o(ri[r+1])
    );
  end

  dcpp_scale u_scale (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(rv[NR]), .item_i(ri[NR]),
    .valid_o(dv[0]), .item_o(di[0])
  );

  for (genvar s = 0; s < ND; s++) begin : g_div
    dcpp_div_step u_step (
      .clk_i, .rst_ni, .en_i(adv), .step_i(5'(ND - 1 - s)),
      .valid_i(dv[s]), .item_i(di[s]), .valid_o(dv[s+1]), .item_o(di[s+1])
    );
  end

  // Saturate, sign and pick the status
  always_comb begin
    fin    = di[ND];
    sat_xp = 1'b0;
    sat_yp = 1'b0;
    if (fin.pt_zero) begin
      xp_d = '0;
    end else if (!fin.neg_x) begin
      sat_xp = fin.ovx || fin.qx[23];
      xp_d   = sat_xp ? dcpp_pkg::PtMax : fin.qx;
    end else begin
      sat_xp = fin.ovx || (fin.qx[23] && (fin.qx[22:0] != '0));
      xp_d   = sat_xp ? dcpp_pkg::PtMin : 24'(~fin.qx + 24'd1);
    end
    if (fin.pt_zero) begin
      yp_d = '0;
    end else if (!fin.neg_y) begin
      sat_yp = fin.ovy || fin.qy[23];
      yp_d   = sat_yp ? dcpp_pkg::PtMax : fin.qy;
    end else begin
      sat_yp = fin.ovy || (fin.qy[23] && (fin.qy[22:0] != '0));
      yp_d   = sat_yp ? dcpp_pkg::PtMin : 24'(~fin.qy + 24'd1);
    end
    sat_xe = fin.ovex;
    sat_ye = fin.ovey;
    xe_d   = (fin.zero_d || sat_xe) ? dcpp_pkg::ErrMax : fin.qex;
    ye_d   = (fin.zero_d || sat_ye) ? dcpp_pkg::ErrMax : fin.qey;
    if (fin.zero_d) begin
      st_d = dcpp_pkg::StatusZero;
    end else if (sat_xp || sat_yp || sat_xe || sat_ye) begin
      st_d = dcpp_pkg::StatusSat;
    end else begin
      st_d = dcpp_pkg::StatusOk;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xp_q <= xp_d;
      yp_q <= yp_d;
      xe_q <= xe_d;
      ye_q <= ye_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_point_o   = xp_q;
  assign y_point_o   = yp_q;
  assign x_err_o     = xe_q;
  assign y_err_o     = ye_q;
  assign status_o    = st_q;

endmodule

[sv/dcpp_checker.sv]
// Port-level checks for the drift circle pair point block, and their bind.
// Depends on dcpp_pkg and drift_circle_pair_point.
module dcpp_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] x_err_o,
  input logic [23:0] y_err_o,
  input logic [1:0]  status_o,
  input logic        pready
);

  // Input only stalls behind a held output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  // Held beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Zero denominator carries full-scale errors
  a_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == dcpp_pkg::StatusZero)) |->
      ((x_err_o == dcpp_pkg::ErrMax) && (y_err_o == dcpp_pkg::ErrMax)))
    else $error("zero denominator without full-scale error");

  // Status code is never the unused one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == dcpp_pkg::StatusOk) ||
      (status_o == dcpp_pkg::StatusZero) || (status_o == dcpp_pkg::StatusSat)))
    else $error("undefined status code");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind drift_circle_pair_point dcpp_assert u_dcpp_assert (
  .clk_i, .rst_ni, .stall_o, .out_valid_o, .out_stall_i,
  .x_err_o, .y_err_o, .status_o, .pready
);
